FILE: rtl/hwq_pkg.sv
// shared types and constants of the haar wavelet quantizer
package hwq_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned BLK_W      = 11;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DETAIL_RECIP   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL_RECIP = 4'd3;

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd256;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd256;
  localparam logic [RECIP_W-1:0] RST_RECIP        = 17'd3277;

  typedef enum logic [1:0] {
    BAND_AVG  = 2'd0,
    BAND_ROW  = 2'd1,
    BAND_COL  = 2'd2,
    BAND_DIAG = 2'd3
  } hwq_band_e;

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2
  } hwq_kind_e;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [RECIP_W-1:0] detail_recip;
    logic [RECIP_W-1:0] diagonal_recip;
  } hwq_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper_left;
    logic [PIX_W-1:0] upper_right;
    logic [PIX_W-1:0] lower_left;
    logic [PIX_W-1:0] lower_right;
    logic [BLK_W-1:0] block_row;
    logic [BLK_W-1:0] block_col;
    logic             last_of_frame;
  } hwq_block_t;

endpackage

FILE: rtl/hwq_ram.sv
// generic single-port ram with registered read
module hwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hwq_front.sv
// front end: raster counters, line buffer and 2x2 block assembly
module hwq_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hwq_pkg::hwq_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         pixel_i,
  output logic               blk_valid_o,
  input  logic               blk_ready_i,
  output hwq_pkg::hwq_block_t blk_o
);
  import hwq_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam int unsigned WLim  = (MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM;

  logic [CNT_W-1:0] col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [DIM_W-1:0] w_eff, h_eff, w_clip, h_clip;
  logic [DIM_W-1:0] row_pre, row_wrap, col_inc, row_inc;
  logic [CNT_W-1:0] col, row;
  logic             accept, s1_done;
  logic [AddrW-1:0] idx;
  logic [PIX_W-1:0] ram_rdata;

  logic             s1_valid_q;
  hwq_kind_e        s1_kind_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [BLK_W-1:0] s1_br_q, s1_bc_q;
  logic             s1_last_q;
  logic [PIX_W-1:0] held_ul_q, held_ll_q;

  // size in use: clamped and rounded down to even
  always_comb begin
    w_clip = cfg_i.image_width;
    if (w_clip > DIM_W'(WLim)) w_clip = DIM_W'(WLim);
    if (w_clip < DIM_W'(2)) w_clip = DIM_W'(2);
    w_eff = {w_clip[DIM_W-1:1], 1'b0};
    h_clip = cfg_i.image_height;
    if (h_clip > DIM_W'(MAX_DIM)) h_clip = DIM_W'(MAX_DIM);
    if (h_clip < DIM_W'(2)) h_clip = DIM_W'(2);
    h_eff = {h_clip[DIM_W-1:1], 1'b0};
  end

  always_comb begin
    if ({1'b0, col_cnt_q} >= w_eff) begin
      col     = '0;
      row_pre = {1'b0, row_cnt_q} + DIM_W'(1);
    end else begin
      col     = col_cnt_q;
      row_pre = {1'b0, row_cnt_q};
    end
    row_wrap = (row_pre >= h_eff) ? '0 : row_pre;
    row      = row_wrap[CNT_W-1:0];
    col_inc  = {1'b0, col} + DIM_W'(1);
    row_inc  = {1'b0, row} + DIM_W'(1);
    if (col_inc >= w_eff) begin
      col_cnt_d = '0;
      row_cnt_d = (row_inc >= h_eff) ? '0 : row_inc[CNT_W-1:0];
    end else begin
      col_cnt_d = col_inc[CNT_W-1:0];
      row_cnt_d = row;
    end
  end

  assign idx        = AddrW'(col);
  assign s1_done    = (s1_kind_q != KIND_RIGHT) || blk_ready_i;
  assign in_ready_o = !s1_valid_q || s1_done;
  assign accept     = in_valid_i && in_ready_o;

  hwq_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (accept && !row[0]),
    .re_i   (accept && row[0]),
    .addr_i (idx),
    .wdata_i(pixel_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      s1_kind_q  <= KIND_STORE;
      held_ul_q  <= '0;
      held_ll_q  <= '0;
    end else begin
      if (accept) begin
        col_cnt_q  <= col_cnt_d;
        row_cnt_q  <= row_cnt_d;
        s1_valid_q <= 1'b1;
        if (!row[0]) begin
          s1_kind_q <= KIND_STORE;
        end else if (!col[0]) begin
          s1_kind_q <= KIND_LEFT;
        end else begin
          s1_kind_q <= KIND_RIGHT;
        end
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_kind_q == KIND_LEFT) begin
        held_ll_q <= s1_px_q;
        held_ul_q <= ram_rdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_br_q   <= row[BLK_W:1];
      s1_bc_q   <= col[BLK_W:1];
      s1_last_q <= (row_inc >= h_eff) && (col_inc >= w_eff);
    end
  end

  assign blk_valid_o         = s1_valid_q && (s1_kind_q == KIND_RIGHT);
  assign blk_o.upper_left    = held_ul_q;
  assign blk_o.upper_right   = ram_rdata;
  assign blk_o.lower_left    = held_ll_q;
  assign blk_o.lower_right   = s1_px_q;
  assign blk_o.block_row     = s1_br_q;
  assign blk_o.block_col     = s1_bc_q;
  assign blk_o.last_of_frame = s1_last_q;

endmodule

FILE: rtl/hwq_queue.sv
// short block queue between front and back ends
module hwq_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  hwq_pkg::hwq_block_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output hwq_pkg::hwq_block_t pop_data_o
);
  import hwq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  hwq_block_t      entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && count_q == '0 |=> pop_valid_o)
    else $error("pushed transaction not visible at queue head");
`endif

endmodule

FILE: rtl/hwq_back.sv
// back end: four results per block, one quantizer multiply per unstalled cycle
module hwq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hwq_pkg::hwq_cfg_t   cfg_i,
  input  logic                blk_valid_i,
  output logic                blk_ready_o,
  input  hwq_pkg::hwq_block_t blk_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          coefficient_o,
  output logic [1:0]          band_o,
  output logic [10:0]         block_row_o,
  output logic [10:0]         block_col_o,
  output logic                last_of_block_o,
  output logic                last_of_frame_o
);
  import hwq_pkg::*;

  localparam int unsigned ProdW = 30;
  localparam logic signed [ProdW-1:0] QuantOffset = 30'sd16777216;

  hwq_block_t  e_q;
  logic        e_valid_q;
  hwq_band_e   k_q;

  logic              out_valid_q;
  logic [PIX_W-1:0]  coef_q;
  hwq_band_e         band_q;
  logic [BLK_W-1:0]  br_q, bc_q;
  logic              lob_q, lof_q;

  logic                    load, pop;
  logic signed [10:0]      pa, pb, pc, pd, diff;
  logic [9:0]              sum;
  logic [RECIP_W:0]        rc;
  logic signed [ProdW-1:0] prod, t;
  logic [11:0]             v;
  logic [PIX_W-1:0]        coef;

  assign load        = e_valid_q && (!out_valid_q || out_ready_i);
  assign pop         = !e_valid_q || (load && k_q == BAND_DIAG);
  assign blk_ready_o = pop;

  always_comb begin
    pa  = signed'({3'b000, e_q.upper_left});
    pb  = signed'({3'b000, e_q.upper_right});
    pc  = signed'({3'b000, e_q.lower_left});
    pd  = signed'({3'b000, e_q.lower_right});
    sum = 10'(e_q.upper_left) + 10'(e_q.upper_right)
        + 10'(e_q.lower_left) + 10'(e_q.lower_right);
    // diagonal uses a 2^16 scale, so its recip is doubled onto the 2^17 scale
    case (k_q)
      BAND_ROW: begin
        diff = pa + pb - pc - pd;
        rc   = {1'b0, cfg_i.detail_recip};
      end
      BAND_COL: begin
        diff = pa - pb + pc - pd;
        rc   = {1'b0, cfg_i.detail_recip};
      end
      BAND_DIAG: begin
        diff = pa - pb - pc + pd;
        rc   = {cfg_i.diagonal_recip, 1'b0};
      end
      default: begin
        diff = '0;
        rc   = '0;
      end
    endcase
    prod = ProdW'(diff) * signed'(ProdW'(rc));
    t    = prod + QuantOffset;
    v    = t[28:17];
    if (k_q == BAND_AVG) begin
      coef = sum[9:2];
    end else if (t[ProdW-1]) begin
      coef = '0;
    end else if (v > 12'd255) begin
      coef = 8'd255;
    end else begin
      coef = v[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      k_q         <= BAND_AVG;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        e_valid_q <= blk_valid_i;
        k_q       <= BAND_AVG;
      end else if (load) begin
        k_q <= hwq_band_e'(k_q + 2'd1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && blk_valid_i) begin
      e_q <= blk_i;
    end
    if (load) begin
      coef_q <= coef;
      band_q <= k_q;
      br_q   <= e_q.block_row;
      bc_q   <= e_q.block_col;
      lob_q  <= (k_q == BAND_DIAG);
      lof_q  <= (k_q == BAND_DIAG) && e_q.last_of_frame;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign coefficient_o   = coef_q;
  assign band_o          = band_q;
  assign block_row_o     = br_q;
  assign block_col_o     = bc_q;
  assign last_of_block_o = lob_q;
  assign last_of_frame_o = lof_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_frame_o |-> band_o == BAND_DIAG)
    else $error("frame end flagged off the diagonal band");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && band_o != BAND_DIAG
      |=> out_valid_o && band_o == $past(band_o) + 2'd1)
    else $error("block results broken up or out of order");
`endif

endmodule

FILE: rtl/haar_wavelet_2d_quantizer.sv
// top level of the one-level 2d haar transform with detail quantization
//
// Grey pixels enter in raster order, one per cycle while in_ready_o is
// high. Even rows go to a line buffer ram; on odd rows each pair of pixels
// closes a 2x2 block, which the front end pushes into a four-entry queue.
// The back end turns each block into four results (average, row-pair,
// column-pair and diagonal bands), one per cycle through a single quantizer
// multiplier while the output is not stalled, so the output port carries
// at most one result per cycle. Even rows only fill the line buffer, while
// odd rows yield two results per pixel and the input stalls once the queue
// is full; rows of up to about two dozen pixels fit the buffering. A block
// passes the front end pixel register, the queue entry, the back end block
// register and the output register on its way to the output.
// The line buffer needs no clearing after reset.
module haar_wavelet_2d_quantizer #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hwq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hwq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     coefficient_o,
  output logic [1:0]                     band_o,
  output logic [10:0]                    block_row_o,
  output logic [10:0]                    block_col_o,
  output logic                           last_of_block_o,
  output logic                           last_of_frame_o
);
  import hwq_pkg::*;

  hwq_cfg_t   cfg_q;
  hwq_block_t front_blk, queue_blk;
  logic       front_valid, front_ready, queue_valid, queue_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= RST_IMAGE_WIDTH;
      cfg_q.image_height   <= RST_IMAGE_HEIGHT;
      cfg_q.detail_recip   <= RST_RECIP;
      cfg_q.diagonal_recip <= RST_RECIP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data_i[DIM_W-1:0];
        REG_DETAIL_RECIP:   cfg_q.detail_recip   <= cfg_data_i[RECIP_W-1:0];
        REG_DIAGONAL_RECIP: cfg_q.diagonal_recip <= cfg_data_i[RECIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hwq_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_i),
    .blk_valid_o(front_valid),
    .blk_ready_i(front_ready),
    .blk_o      (front_blk)
  );

  hwq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_data_i (front_blk),
    .pop_valid_o (queue_valid),
    .pop_ready_i (queue_ready),
    .pop_data_o  (queue_blk)
  );

  hwq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .blk_valid_i    (queue_valid),
    .blk_ready_o    (queue_ready),
    .blk_i          (queue_blk),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coefficient_o  (coefficient_o),
    .band_o         (band_o),
    .block_row_o    (block_row_o),
    .block_col_o    (block_col_o),
    .last_of_block_o(last_of_block_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule
